FILE: rtl/core/khrs_pkg.sv
// Package for the keyed hash range sampler: mixing constants, shift amounts,
// stage counts and register map. No dependencies.

package khrs_pkg;

  localparam int unsigned COORD_WIDTH = 32;

  localparam logic [63:0] GOLDEN_ADD = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;
  localparam logic [63:0] SALT_X     = 64'hA0761D6478BD642F;
  localparam logic [63:0] SALT_Y     = 64'hE7037ED1A0B428DB;

  localparam int unsigned SHIFT_A = 30;
  localparam int unsigned SHIFT_B = 27;
  localparam int unsigned SHIFT_C = 31;

  localparam int unsigned MIX_STAGES  = 5;
  localparam int unsigned PICK_STAGES = 3;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned CAND_W = 32;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 64;

  typedef enum logic [0:0] {
    REG_WORLD_SEED = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_idx_e;

endpackage

FILE: rtl/core/khrs_mix.sv
// One pipelined 64-bit finalizer round: xor in a word, then add, shift-xor and
// multiply twice. Each 64-bit product is built from 32-bit partial products. Uses khrs_pkg.

module khrs_mix #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [63:0]       key_i,
  input  logic [63:0]       word_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [63:0]       hash_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned NS = khrs_pkg::MIX_STAGES;

  logic [NS-1:0]     valid_q;
  logic [SIDE_W-1:0] side_q [NS];

  logic [63:0] x_q, x_d;
  logic [63:0] a0_q, a0_d;
  logic [31:0] a1_q, a1_d, a2_q, a2_d;
  logic [63:0] y_q, y_d;
  logic [63:0] b0_q, b0_d;
  logic [31:0] b1_q, b1_d, b2_q, b2_d;
  logic [63:0] h_q, h_d;

  logic [63:0] m, p, q;
  logic [31:0] a_mid, b_mid;

  always_comb begin
    m     = (key_i ^ word_i) + khrs_pkg::GOLDEN_ADD;
    x_d   = m ^ (m >> khrs_pkg::SHIFT_A);
    a0_d  = 64'(x_q[31:0]) * 64'(khrs_pkg::MIX_MUL_A[31:0]);
    a1_d  = x_q[31:0] * khrs_pkg::MIX_MUL_A[63:32];
    a2_d  = x_q[63:32] * khrs_pkg::MIX_MUL_A[31:0];
    a_mid = a1_q + a2_q;
    p     = a0_q + {a_mid, 32'h0};
    y_d   = p ^ (p >> khrs_pkg::SHIFT_B);
    b0_d  = 64'(y_q[31:0]) * 64'(khrs_pkg::MIX_MUL_B[31:0]);
    b1_d  = y_q[31:0] * khrs_pkg::MIX_MUL_B[63:32];
    b2_d  = y_q[63:32] * khrs_pkg::MIX_MUL_B[31:0];
    b_mid = b1_q + b2_q;
    q     = b0_q + {b_mid, 32'h0};
    h_d   = q ^ (q >> khrs_pkg::SHIFT_C);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_d;
      a0_q <= a0_d;
      a1_q <= a1_d;
      a2_q <= a2_d;
      y_q  <= y_d;
      b0_q <= b0_d;
      b1_q <= b1_d;
      b2_q <= b2_d;
      h_q  <= h_d;
      side_q[0] <= side_i;
      for (int i = 1; i < NS; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign hash_o  = h_q;
  assign side_o  = side_q[NS-1];

endmodule

FILE: rtl/core/khrs_pick.sv
// Maps the top 32 bits of two hashes into signed half-open ranges, x and y
// lanes side by side, in three register stages. Uses khrs_pkg.

module khrs_pick #(
  parameter int unsigned COORD_WIDTH = khrs_pkg::COORD_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [63:0]            hash_x_i,
  input  logic [63:0]            hash_y_i,
  input  logic [COORD_WIDTH-1:0] min_x_i,
  input  logic [COORD_WIDTH-1:0] max_x_i,
  input  logic [COORD_WIDTH-1:0] min_y_i,
  input  logic [COORD_WIDTH-1:0] max_y_i,
  output logic                   valid_o,
  output logic [COORD_WIDTH-1:0] pos_x_o,
  output logic [COORD_WIDTH-1:0] pos_y_o
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned LO_W   = (CW < 32) ? CW : 32;
  localparam int unsigned HI_W   = (CW > 32) ? CW - 32 : 1;
  localparam int unsigned OFF_W  = HI_W + 33;
  localparam int unsigned NS     = khrs_pkg::PICK_STAGES;

  logic [NS-1:0] valid_q;

  logic [CW-1:0] min_v [2];
  logic [CW-1:0] max_v [2];
  logic [63:0]   hash_v [2];

  logic [CW:0]       diff   [2];
  logic [CW-1:0]     lo0_q  [2];
  logic [CW-1:0]     span_q [2];
  logic [1:0]        empty0_q, empty0_d, empty1_q;
  logic [31:0]       t_q    [2];
  logic [HI_W-1:0]   span_hi [2];
  logic [CW-1:0]     lo1_q  [2];
  logic [LO_W+31:0]  mlo_q  [2];
  logic [HI_W+31:0]  mhi_q  [2];
  logic [OFF_W-1:0]  off    [2];
  logic [CW-1:0]     pos_q  [2];
  logic [CW-1:0]     pos_d  [2];

  assign min_v[0]  = min_x_i;
  assign min_v[1]  = min_y_i;
  assign max_v[0]  = max_x_i;
  assign max_v[1]  = max_y_i;
  assign hash_v[0] = hash_x_i;
  assign hash_v[1] = hash_y_i;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    if (CW > 32) begin : g_hi
      assign span_hi[l] = span_q[l][CW-1:32];
    end else begin : g_nohi
      assign span_hi[l] = '0;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      diff[l]     = {max_v[l][CW-1], max_v[l]} - {min_v[l][CW-1], min_v[l]};
      empty0_d[l] = diff[l][CW] || (diff[l] == '0);
      off[l]      = OFF_W'(mhi_q[l]) + OFF_W'(mlo_q[l][LO_W+31:32]);
      pos_d[l]    = empty1_q[l] ? lo1_q[l] : lo1_q[l] + CW'(off[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      empty0_q <= empty0_d;
      empty1_q <= empty0_q;
      for (int l = 0; l < 2; l++) begin
        lo0_q[l]  <= min_v[l];
        span_q[l] <= diff[l][CW-1:0];
        t_q[l]    <= hash_v[l][63:32];
        lo1_q[l]  <= lo0_q[l];
        mlo_q[l]  <= (LO_W+32)'(span_q[l][LO_W-1:0]) * (LO_W+32)'(t_q[l]);
        mhi_q[l]  <= (HI_W+32)'(span_hi[l]) * (HI_W+32)'(t_q[l]);
        pos_q[l]  <= pos_d[l];
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign pos_x_o = pos_q[0];
  assign pos_y_o = pos_q[1];

endmodule

FILE: rtl/core/keyed_hash_range_sampler_core.sv
// Keyed hash range sampler: five chained finalizer rounds, then parallel x and y salt rounds,
// a range mapper and an output register with a skid stage. Uses khrs_pkg, khrs_mix and khrs_pick.
// From word acceptance to m_axis_tvalid_o a word passes 30 finalizer stages, 3 mapper
// stages and the output register, the first stage loading at the accepting edge.
// Throughput: one word per cycle while the skid stage is empty, set by the fully pipelined rounds.
// Reset clears all valid bits, the skid stage and world_seed (to zero).

module keyed_hash_range_sampler_core #(
  parameter int unsigned COORD_WIDTH = khrs_pkg::COORD_WIDTH,
  localparam int unsigned IN_W   = 3 * khrs_pkg::KEY_W + khrs_pkg::CAND_W + 4 * COORD_WIDTH,
  localparam int unsigned IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W  = 2 * COORD_WIDTH,
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // map_instance, entity, revision_number, candidate, min_x, min_y, max_x, max_y
  input  logic [IN_TW-1:0]             s_axis_tdata_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // pos_x, pos_y
  output logic [OUT_TW-1:0]            m_axis_tdata_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [khrs_pkg::ADDR_W-1:0]  paddr_i,
  input  logic [khrs_pkg::DATA_W-1:0]  pwdata_i,
  output logic [khrs_pkg::DATA_W-1:0]  prdata_o,
  output logic                         pready_o
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned S0_W   = IN_W;
  localparam int unsigned S1_W   = S0_W - 64;
  localparam int unsigned S2_W   = S1_W - 64;
  localparam int unsigned S3_W   = S2_W - 64;
  localparam int unsigned S4_W   = S3_W - 32;
  localparam int unsigned SXY_W  = 2 * CW;

  logic [63:0] world_seed_q;
  logic        en;

  logic [S0_W-1:0] side0;
  logic [S1_W-1:0] side1;
  logic [S2_W-1:0] side2;
  logic [S3_W-1:0] side3;
  logic [S4_W-1:0] side4;
  logic [SXY_W-1:0] side_x, side_y;
  logic [63:0] key0, key1, key2, key3, key4, hash_x, hash_y;
  logic v0, v1, v2, v3, v4, vx, vy, vp;
  logic [CW-1:0] pos_x, pos_y;

  logic             out_valid_q, skid_valid_q;
  logic [OUT_W-1:0] out_data_q, skid_data_q;
  logic             pop, push;

  logic [S0_W-1:0] side1_full, side2_full, side3_full, side4_full, side5_full;

  // Configuration port.
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[3] == khrs_pkg::REG_WORLD_SEED) ? world_seed_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_seed_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 paddr_i[3] == khrs_pkg::REG_WORLD_SEED) begin
      world_seed_q <= pwdata_i;
    end
  end

  // Key chain.
  assign en              = !skid_valid_q;
  assign s_axis_tready_o = en;
  assign side0           = s_axis_tdata_i[IN_W-1:0];

  khrs_mix #(.SIDE_W(S0_W)) u_mix_seed (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid_i),
    .key_i(world_seed_q), .word_i(64'h0), .side_i(side0),
    .valid_o(v0), .hash_o(key0), .side_o(side1_full)
  );

  assign side1 = side1_full[S0_W-1:64];

  khrs_mix #(.SIDE_W(S1_W)) u_mix_map (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0),
    .key_i(key0), .word_i(side1_full[63:0]), .side_i(side1),
    .valid_o(v1), .hash_o(key1), .side_o(side2_full[S1_W-1:0])
  );
  assign side2_full[S0_W-1:S1_W] = '0;
  assign side2 = side2_full[S1_W-1:64];

  khrs_mix #(.SIDE_W(S2_W)) u_mix_entity (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1),
    .key_i(key1), .word_i(side2_full[63:0]), .side_i(side2),
    .valid_o(v2), .hash_o(key2), .side_o(side3_full[S2_W-1:0])
  );
  assign side3_full[S0_W-1:S2_W] = '0;
  assign side3 = side3_full[S2_W-1:64];

  khrs_mix #(.SIDE_W(S3_W)) u_mix_revision (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2),
    .key_i(key2), .word_i(side3_full[63:0]), .side_i(side3),
    .valid_o(v3), .hash_o(key3), .side_o(side4_full[S3_W-1:0])
  );
  assign side4_full[S0_W-1:S3_W] = '0;
  assign side4 = side4_full[S3_W-1:32];

  khrs_mix #(.SIDE_W(S4_W)) u_mix_candidate (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3),
    .key_i(key3), .word_i({32'h0, side4_full[31:0]}), .side_i(side4),
    .valid_o(v4), .hash_o(key4), .side_o(side5_full[S4_W-1:0])
  );
  assign side5_full[S0_W-1:S4_W] = '0;

  // Bounds are packed min_x, min_y, max_x, max_y from the lowest bit.
  assign side_x = {side5_full[2*CW +: CW], side5_full[0 +: CW]};
  assign side_y = {side5_full[3*CW +: CW], side5_full[CW +: CW]};

  logic [SXY_W-1:0] bnd_x, bnd_y;

  khrs_mix #(.SIDE_W(SXY_W)) u_mix_salt_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4),
    .key_i(key4), .word_i(khrs_pkg::SALT_X), .side_i(side_x),
    .valid_o(vx), .hash_o(hash_x), .side_o(bnd_x)
  );

  khrs_mix #(.SIDE_W(SXY_W)) u_mix_salt_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4),
    .key_i(key4), .word_i(khrs_pkg::SALT_Y), .side_i(side_y),
    .valid_o(vy), .hash_o(hash_y), .side_o(bnd_y)
  );

  khrs_pick #(.COORD_WIDTH(CW)) u_pick (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vx),
    .hash_x_i(hash_x), .hash_y_i(hash_y),
    .min_x_i(bnd_x[CW-1:0]), .max_x_i(bnd_x[2*CW-1:CW]),
    .min_y_i(bnd_y[CW-1:0]), .max_y_i(bnd_y[2*CW-1:CW]),
    .valid_o(vp), .pos_x_o(pos_x), .pos_y_o(pos_y)
  );

  // Output register with a skid stage; the pipeline holds while the skid is full.
  assign pop  = out_valid_q && m_axis_tready_i;
  assign push = en && vp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_data_q <= {pos_y, pos_x};
      end else begin
        skid_data_q <= {pos_y, pos_x};
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TW'(out_data_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni) vx == vy)
    else $error("Salted hash lanes are out of step.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("Skid stage holds a word while the output register is empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready_i && vp))
    else $error("Skid stage filled without a stalled output.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !m_axis_tready_i |=> skid_valid_q && $stable(skid_data_q))
    else $error("Skid word lost while the output is stalled.");

endmodule

FILE: tb/sv/keyed_hash_range_sampler_core_tb.sv
// Testbench for keyed_hash_range_sampler_core: random and directed sample requests over
// several world seeds, each result checked against a scoreboard that recomputes the hash.
// Depends on khrs_pkg and the core itself.

module keyed_hash_range_sampler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW     = khrs_pkg::COORD_WIDTH;
  localparam int unsigned KEY_W  = khrs_pkg::KEY_W;
  localparam int unsigned CAND_W = khrs_pkg::CAND_W;
  localparam int unsigned ADDR_W = khrs_pkg::ADDR_W;
  localparam int unsigned DATA_W = khrs_pkg::DATA_W;
  localparam int unsigned IN_W   = 3 * KEY_W + CAND_W + 4 * CW;
  localparam int unsigned OUT_W  = 2 * CW;
  localparam int unsigned LIMIT  = 400000;
  localparam int unsigned DRAIN  = 60;

  typedef struct packed {
    logic signed [CW-1:0] max_y;
    logic signed [CW-1:0] max_x;
    logic signed [CW-1:0] min_y;
    logic signed [CW-1:0] min_x;
    logic [CAND_W-1:0]    candidate;
    logic [KEY_W-1:0]     revision;
    logic [KEY_W-1:0]     entity;
    logic [KEY_W-1:0]     map_inst;
  } sample_req_t;

  typedef struct packed {
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_x;
  } sample_pos_t;

  class sample_board;
    logic [KEY_W-1:0] seed;
    sample_pos_t      expected_pos[$];
    int unsigned      mismatches;
    int unsigned      requests;
    int unsigned      checked;

    function new();
      seed        = '0;
      mismatches  = 0;
      requests    = 0;
      checked     = 0;
    endfunction

    function logic [63:0] finalize(logic [63:0] v);
      logic [63:0] m;
      m = v + khrs_pkg::GOLDEN_ADD;
      m = (m ^ (m >> khrs_pkg::SHIFT_A)) * khrs_pkg::MIX_MUL_A;
      m = (m ^ (m >> khrs_pkg::SHIFT_B)) * khrs_pkg::MIX_MUL_B;
      return m ^ (m >> khrs_pkg::SHIFT_C);
    endfunction

    function logic [CW-1:0] scale_into(logic signed [CW-1:0] lo,
                                       logic signed [CW-1:0] hi,
                                       logic [63:0] h);
      logic [CW-1:0]  span;
      logic [CW+31:0] prod;
      if (hi <= lo) return lo;
      span = hi - lo;
      prod = (CW+32)'(span) * (CW+32)'(h[63:32]);
      return lo + prod[CW+31:32];
    endfunction

    function sample_pos_t predict_pos(sample_req_t r);
      logic [63:0] key;
      sample_pos_t p;
      key = finalize(seed);
      key = finalize(key ^ r.map_inst);
      key = finalize(key ^ r.entity);
      key = finalize(key ^ r.revision);
      key = finalize(key ^ {32'b0, r.candidate});
      p.pos_x = scale_into(r.min_x, r.max_x, finalize(key ^ khrs_pkg::SALT_X));
      p.pos_y = scale_into(r.min_y, r.max_y, finalize(key ^ khrs_pkg::SALT_Y));
      return p;
    endfunction

    function void note_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      if (khrs_pkg::reg_idx_e'(addr[3]) == khrs_pkg::REG_WORLD_SEED) seed = data;
    endfunction

    function void note_request(sample_req_t r);
      expected_pos.push_back(predict_pos(r));
      requests++;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_sample(sample_pos_t got);
      sample_pos_t want;
      if (expected_pos.size() == 0) begin
        flag($sformatf("unexpected result x=%h y=%h", got.pos_x, got.pos_y));
        return;
      end
      want = expected_pos.pop_front();
      checked++;
      if (got.pos_x !== want.pos_x)
        flag($sformatf("pos_x expected %h actual %h", want.pos_x, got.pos_x));
      if (got.pos_y !== want.pos_y)
        flag($sformatf("pos_y expected %h actual %h", want.pos_y, got.pos_y));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic [IN_W-1:0]    s_tdata = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [OUT_W-1:0]   m_tdata;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  sample_board board = new();
  int unsigned cycles = 0;
  int unsigned gap_max = 16;
  int unsigned seed_settings = 1;

  keyed_hash_range_sampler_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) board.note_request(sample_req_t'(s_tdata));
      if (m_tvalid && m_tready) board.check_sample(sample_pos_t'(m_tdata));
      if (psel && penable && pwrite && pready) board.note_write(paddr, pwdata);
    end
  end

  function automatic int unsigned draw_gap();
    if (gap_max == 0 || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, gap_max);
  endfunction

  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
    end
  end

  task automatic send_req(input sample_req_t r);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tdata  <= r;
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic finish_stream();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_pos.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input khrs_pkg::reg_idx_e idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (idx == khrs_pkg::REG_WORLD_SEED) seed_settings++;
  endtask

  task automatic apb_check_seed();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {khrs_pkg::REG_WORLD_SEED, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== board.seed)
      board.flag($sformatf("world_seed read expected %h actual %h", board.seed, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic rand_bounds(output logic signed [CW-1:0] lo, output logic signed [CW-1:0] hi);
    logic signed [CW-1:0] a;
    a = $urandom;
    case ($urandom_range(0, 9))
      0: begin lo = a; hi = a; end
      1: begin lo = a; hi = a - CW'($urandom_range(1, 1 << 20)); end
      2: begin lo = a; hi = a + 1; end
      3: begin lo = {1'b1, {(CW-1){1'b0}}}; hi = {1'b0, {(CW-1){1'b1}}}; end
      4, 5: begin
        lo = CW'($signed($urandom_range(0, 2000 << 16)) - $signed(1000 << 16));
        hi = lo + CW'($urandom_range(0, 200 << 16));
      end
      default: begin lo = a; hi = $urandom; end
    endcase
  endtask

  function automatic sample_req_t rand_req();
    sample_req_t r;
    r.map_inst  = rand_key();
    r.entity    = rand_key();
    r.revision  = rand_key();
    r.candidate = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
    return r;
  endfunction

  task automatic send_fixed(input logic [63:0] k, input logic [CAND_W-1:0] c,
                            input logic signed [CW-1:0] lo, input logic signed [CW-1:0] hi);
    sample_req_t r;
    r = '{max_y: hi, max_x: hi, min_y: lo, min_x: lo, candidate: c,
          revision: k, entity: k, map_inst: k};
    send_req(r);
  endtask

  task automatic run_random(input int unsigned count);
    sample_req_t r;
    repeat (count) begin
      r = rand_req();
      rand_bounds(r.min_x, r.max_x);
      rand_bounds(r.min_y, r.max_y);
      send_req(r);
    end
    finish_stream();
  endtask

  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

  initial begin
    sample_req_t r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_check_seed();
    send_fixed('0, '0, '0, '0);
    send_fixed('1, '1, C_MIN, C_MAX);
    send_fixed('0, '0, C_MIN, C_MAX);
    send_fixed('1, '0, C_MAX, C_MIN);
    send_fixed(64'h1, 32'h1, 32'sd5, 32'sd6);
    send_fixed(64'h8000_0000_0000_0000, 32'h8000_0000, -32'sd1, -32'sd1);
    send_fixed(64'h0123_4567_89AB_CDEF, 32'h7, 32'sd0, 32'sh0064_0000);
    send_fixed(64'hFEDC_BA98_7654_3210, 32'hFFFF_FFFE, -32'sh0064_0000, -32'sh0032_0000);
    send_fixed('1, '1, C_MAX - 1, C_MAX);
    send_fixed('0, '1, C_MIN, C_MIN + 1);
    r = '{max_y: C_MIN, max_x: C_MAX, min_y: C_MAX, min_x: C_MIN, candidate: 32'h5A5A_A5A5,
          revision: '1, entity: '0, map_inst: 64'hAAAA_AAAA_AAAA_AAAA};
    send_req(r);
    finish_stream();

    apb_write(khrs_pkg::REG_UNUSED, {$urandom, $urandom});
    apb_check_seed();
    send_fixed('0, '0, C_MIN, C_MAX);
    send_fixed(64'h5555_5555_5555_5555, 32'h3, -32'sd100, 32'sd100);
    finish_stream();

    apb_write(khrs_pkg::REG_WORLD_SEED, '1);
    apb_check_seed();
    send_fixed('0, '0, C_MIN, C_MAX);
    send_fixed('1, '1, C_MIN, C_MAX);
    send_fixed('0, '0, 32'sd7, 32'sd7);
    finish_stream();
    run_random(100);

    apb_write(khrs_pkg::REG_WORLD_SEED, 64'h1);
    apb_check_seed();
    gap_max = 0;
    run_random(110);
    gap_max = 16;

    apb_write(khrs_pkg::REG_WORLD_SEED, 64'h8000_0000_0000_0000);
    apb_check_seed();
    run_random(110);

    apb_write(khrs_pkg::REG_WORLD_SEED, {$urandom, $urandom});
    apb_check_seed();
    run_random(110);

    apb_write(khrs_pkg::REG_WORLD_SEED, '0);
    apb_check_seed();
    gap_max = 4;
    run_random(110);

    repeat (DRAIN) @(posedge clk_i);
    while (board.expected_pos.size() != 0) begin
      void'(board.expected_pos.pop_front());
      board.flag("expected result never arrived");
    end

    $display("Sent %0d sample requests under %0d seed settings, %0d results checked.",
             board.requests, seed_settings, board.checked);
    $display("Mismatches: %0d.", board.mismatches);
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/khrs_pkg.sv
rtl/core/khrs_mix.sv
rtl/core/khrs_pick.sv
rtl/core/keyed_hash_range_sampler_core.sv
tb/sv/keyed_hash_range_sampler_core_tb.sv
